[src/fcq_pkg.sv]
`timescale 1ns / 1ps

package fcq_pkg;

	// datapath widths
	localparam int ACC_W  = 60;
	localparam int A_W    = 37;
	localparam int B_W    = 23;
	localparam int CW     = 34;
	localparam int ZW     = 33;
	localparam int ATAN_N = 24;
	localparam int AI_W   = 5;

	// fixed start gain of the rotator, q2.30
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	// one over two pi, q8.24
	localparam logic signed [B_W-1:0] INV_TWO_PI = 23'sd2670177;

	// atan(2^-i) in units of 2^-32 turn
	localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic [15:0] yaw_amount;
		logic [15:0] pitch_amount;
		logic [15:0] roll_amount;
		logic [15:0] forward_amount;
		logic [15:0] right_amount;
		logic [15:0] up_amount;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic        reset_angles;
		logic        clear_move;
	} in_item_t;

	typedef struct packed {
		in_item_t raw;
		logic     has_move;
	} item_t;

	typedef struct packed {
		logic [15:0] movement_speed;
		logic [15:0] rotation_speed;
		logic [15:0] up_multiplier;
		logic        invert_look;
		logic [15:0] initial_pitch;
		logic [15:0] initial_yaw;
		logic [15:0] initial_roll;
	} cfg_t;

	typedef struct packed {
		logic [31:0] new_x;
		logic [31:0] new_y;
		logic [31:0] new_z;
		logic [15:0] quat_w;
		logic [15:0] quat_x;
		logic [15:0] quat_y;
		logic [15:0] quat_z;
	} result_t;

	typedef enum logic [2:0] {
		REG_MOVEMENT_SPEED = 3'd0,
		REG_ROTATION_SPEED = 3'd1,
		REG_UP_MULTIPLIER  = 3'd2,
		REG_INVERT_LOOK    = 3'd3,
		REG_INITIAL_PITCH  = 3'd4,
		REG_INITIAL_YAW    = 3'd5,
		REG_INITIAL_ROLL   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_CORDIC,
		ST_QUAT,
		ST_OUT
	} back_state_t;

endpackage

[src/fcq_front.sv]
`timescale 1ns / 1ps

module fcq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fcq_pkg::in_item_t in_item,
	output logic              pop_valid,
	input  logic              pop_ready,
	output fcq_pkg::item_t    pop_item
);

	fcq_pkg::item_t q_mem [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;
	logic           push;
	logic           pop;
	fcq_pkg::item_t entry;

	// classify: does this frame move the camera
	always_comb begin
		entry.raw      = in_item;
		entry.has_move = (|in_item.forward_amount) | (|in_item.right_amount) |
			(|in_item.up_amount);
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign push      = in_valid & in_ready;
	assign pop       = pop_valid & pop_ready;
	assign pop_item  = q_mem[rd_q];

	// two-entry queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_q] <= entry;
	end

endmodule

[src/fcq_cordic.sv]
`timescale 1ns / 1ps

module fcq_cordic #(
	parameter int STEPS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2:0][31:0] phase,
	output logic             done,
	output logic [2:0][16:0] cos_o,
	output logic [2:0][16:0] sin_o
);

	localparam int CW    = fcq_pkg::CW;
	localparam int ZW    = fcq_pkg::ZW;
	localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic                 busy_q;
	logic                 fin_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [CW-1:0] x_q [3];
	logic signed [CW-1:0] y_q [3];
	logic signed [ZW-1:0] z_q [3];
	logic [1:0]           quad_q [3];
	logic [2:0][16:0]     cos_q;
	logic [2:0][16:0]     sin_q;
	logic                 last;
	logic signed [ZW-1:0] atan_v;

	// round by 2^15 and saturate to q1.15
	function automatic logic [16:0] rsat(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] r;
		r = (v + CW'(16384)) >>> 15;
		if (r > CW'(32767))
			rsat = 17'h07FFF;
		else if (r < -CW'(32768))
			rsat = 17'h18000;
		else
			rsat = r[16:0];
	endfunction

	assign last   = (cnt_q == CNT_W'(STEPS - 1));
	assign atan_v = $signed({1'b0, fcq_pkg::ATAN_TAB[fcq_pkg::AI_W'(cnt_q)]});
	assign done   = done_q;
	assign cos_o  = cos_q;
	assign sin_o  = sin_q;

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q  <= busy_q & last;
			done_q <= fin_q;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (last)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// three rotation lanes, one micro-rotation per cycle
	always_ff @(posedge clk) begin
		logic [16:0] xr;
		logic [16:0] yr;
		for (int k = 0; k < 3; k++) begin
			if (start) begin
				x_q[k]    <= fcq_pkg::CORDIC_GAIN;
				y_q[k]    <= '0;
				z_q[k]    <= $signed({3'b000, phase[k][29:0]});
				quad_q[k] <= phase[k][31:30];
			end else if (busy_q) begin
				if (!z_q[k][ZW-1]) begin
					x_q[k] <= x_q[k] - (y_q[k] >>> cnt_q);
					y_q[k] <= y_q[k] + (x_q[k] >>> cnt_q);
					z_q[k] <= z_q[k] - atan_v;
				end else begin
					x_q[k] <= x_q[k] + (y_q[k] >>> cnt_q);
					y_q[k] <= y_q[k] - (x_q[k] >>> cnt_q);
					z_q[k] <= z_q[k] + atan_v;
				end
			end
			// quadrant turn of the rounded result
			if (fin_q) begin
				xr = rsat(x_q[k]);
				yr = rsat(y_q[k]);
				case (quad_q[k])
					2'd0: begin
						cos_q[k] <= xr;
						sin_q[k] <= yr;
					end
					2'd1: begin
						cos_q[k] <= 17'h0 - yr;
						sin_q[k] <= xr;
					end
					2'd2: begin
						cos_q[k] <= 17'h0 - xr;
						sin_q[k] <= 17'h0 - yr;
					end
					default: begin
						cos_q[k] <= yr;
						sin_q[k] <= 17'h0 - xr;
					end
				endcase
			end
		end
	end

endmodule

[src/fcq_back.sv]
`timescale 1ns / 1ps

module fcq_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcq_pkg::cfg_t     cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  fcq_pkg::item_t    pop_item,
	output logic              out_valid,
	input  logic              out_ready,
	output fcq_pkg::result_t  result
);

	localparam int AW  = fcq_pkg::ACC_W;
	localparam int A_W = fcq_pkg::A_W;
	localparam int B_W = fcq_pkg::B_W;
	localparam logic [4:0] ANG_LAST  = 5'd10;
	localparam logic [4:0] QUAT_LAST = 5'd27;
	localparam logic signed [AW-1:0] MAX32 = AW'(2147483647);
	localparam logic signed [AW-1:0] MIN32 = -MAX32 - AW'(1);
	localparam logic signed [AW-1:0] MAX16 = AW'(32767);
	localparam logic signed [AW-1:0] MIN16 = -AW'(32768);

	fcq_pkg::back_state_t state_q, state_d;
	logic [4:0]           cnt_q, cnt_d;
	fcq_pkg::item_t       item_q;
	logic [15:0]          yaw_q, pitch_q, roll_q;
	logic [31:0]          mv_q [3];
	logic                 moved_q;
	logic [15:0]          tq_q [4];
	logic [15:0]          qo_q [4];
	logic [35:0]          tt_q [3];
	logic [31:0]          res_x_q, res_y_q, res_z_q;
	fcq_pkg::result_t     out_q;
	logic                 out_valid_q;
	logic signed [AW-1:0] acc_q;

	logic signed [A_W-1:0] mul_a;
	logic signed [B_W-1:0] mul_b;
	logic                  mac_clr;
	logic                  mac_sub;
	logic signed [AW-1:0]  prod;
	logic signed [AW-1:0]  r31, r15, r14, r7;
	logic signed [A_W-1:0] acc_a;
	logic                  cor_start;
	logic                  cor_done;
	logic                  out_load;
	logic [2:0][31:0]      cor_phase;
	logic [2:0][16:0]      cor_cos;
	logic [2:0][16:0]      cor_sin;
	logic [31:0]           v0, v1, v2;
	logic [15:0]           dang;

	// operand extension
	function automatic logic signed [A_W-1:0] au16(input logic [15:0] v);
		return $signed({{(A_W-16){1'b0}}, v});
	endfunction
	function automatic logic signed [A_W-1:0] as16(input logic [15:0] v);
		return $signed({{(A_W-16){v[15]}}, v});
	endfunction
	function automatic logic signed [A_W-1:0] as17(input logic [16:0] v);
		return $signed({{(A_W-17){v[16]}}, v});
	endfunction
	function automatic logic signed [A_W-1:0] as32(input logic [31:0] v);
		return $signed({{(A_W-32){v[31]}}, v});
	endfunction
	function automatic logic signed [A_W-1:0] as36(input logic [35:0] v);
		return $signed({{(A_W-36){v[35]}}, v});
	endfunction
	function automatic logic signed [B_W-1:0] bu16(input logic [15:0] v);
		return $signed({{(B_W-16){1'b0}}, v});
	endfunction
	function automatic logic signed [B_W-1:0] bs16(input logic [15:0] v);
		return $signed({{(B_W-16){v[15]}}, v});
	endfunction
	function automatic logic signed [B_W-1:0] bs17(input logic [16:0] v);
		return $signed({{(B_W-17){v[16]}}, v});
	endfunction
	function automatic logic signed [AW-1:0] acc32(input logic [31:0] v);
		return $signed({{(AW-32){v[31]}}, v});
	endfunction
	function automatic logic [31:0] sat32(input logic signed [AW-1:0] v);
		if (v > MAX32)
			return 32'h7FFFFFFF;
		else if (v < MIN32)
			return 32'h80000000;
		else
			return v[31:0];
	endfunction
	function automatic logic [15:0] sat16(input logic signed [AW-1:0] v);
		if (v > MAX16)
			return 16'h7FFF;
		else if (v < MIN16)
			return 16'h8000;
		else
			return v[15:0];
	endfunction

	// rounded shifts of the accumulator
	assign r31   = (acc_q + (AW'(1) <<< 30)) >>> 31;
	assign r15   = (acc_q + (AW'(1) <<< 14)) >>> 15;
	assign r14   = (acc_q + (AW'(1) <<< 13)) >>> 14;
	assign r7    = (acc_q + (AW'(1) <<< 6)) >>> 7;
	assign acc_a = acc_q[A_W-1:0];
	assign dang  = r31[15:0];

	// move vector as seen by the rotation
	assign v0 = moved_q ? mv_q[0] : 32'h0;
	assign v1 = moved_q ? mv_q[1] : 32'h0;
	assign v2 = moved_q ? mv_q[2] : 32'h0;

	// half-angle phases: z lane takes minus yaw
	assign cor_phase[0] = 32'h0 - {1'b0, yaw_q, 15'h0};
	assign cor_phase[1] = {1'b0, pitch_q, 15'h0};
	assign cor_phase[2] = {1'b0, roll_q, 15'h0};

	fcq_cordic #(
		.STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.phase  (cor_phase),
		.done   (cor_done),
		.cos_o  (cor_cos),
		.sin_o  (cor_sin)
	);

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pop_ready = 1'b0;
		cor_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			fcq_pkg::ST_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = fcq_pkg::ST_ANGLE;
					cnt_d   = 5'd0;
				end
			end
			fcq_pkg::ST_ANGLE: begin
				if (cnt_q == ANG_LAST) begin
					cor_start = 1'b1;
					state_d   = fcq_pkg::ST_CORDIC;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			fcq_pkg::ST_CORDIC: begin
				if (cor_done) begin
					state_d = fcq_pkg::ST_QUAT;
					cnt_d   = 5'd0;
				end
			end
			fcq_pkg::ST_QUAT: begin
				if (cnt_q == QUAT_LAST)
					state_d = fcq_pkg::ST_OUT;
				else
					cnt_d = cnt_q + 5'd1;
			end
			fcq_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = fcq_pkg::ST_IDLE;
				end
			end
			default: state_d = fcq_pkg::ST_IDLE;
		endcase
	end

	// multiply-accumulate operand schedule
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mac_clr = 1'b1;
		mac_sub = 1'b0;
		if (state_q == fcq_pkg::ST_ANGLE) begin
			case (cnt_q)
				5'd0: begin
					mul_a = au16(cfg.rotation_speed);
					mul_b = bs16(item_q.raw.yaw_amount);
				end
				5'd1, 5'd3, 5'd5: begin
					mul_a = acc_a;
					mul_b = fcq_pkg::INV_TWO_PI;
				end
				5'd2: begin
					mul_a = au16(cfg.rotation_speed);
					mul_b = bs16(item_q.raw.pitch_amount);
				end
				5'd4: begin
					mul_a = au16(cfg.rotation_speed);
					mul_b = bs16(item_q.raw.roll_amount);
				end
				5'd6: begin
					mul_a = au16(cfg.movement_speed);
					mul_b = bs16(item_q.raw.right_amount);
				end
				5'd7: begin
					mul_a = au16(cfg.movement_speed);
					mul_b = bs16(item_q.raw.forward_amount);
				end
				5'd8: begin
					mul_a = au16(cfg.movement_speed);
					mul_b = bu16(cfg.up_multiplier);
				end
				5'd9: begin
					mul_a = acc_a;
					mul_b = bs16(item_q.raw.up_amount);
				end
				default: ;
			endcase
		end else if (state_q == fcq_pkg::ST_QUAT) begin
			case (cnt_q)
				// z times x quaternion
				5'd0: begin
					mul_a = as17(cor_cos[0]);
					mul_b = bs17(cor_cos[1]);
				end
				5'd1: begin
					mul_a = as17(cor_cos[0]);
					mul_b = bs17(cor_sin[1]);
				end
				5'd2: begin
					mul_a = as17(cor_sin[0]);
					mul_b = bs17(cor_sin[1]);
				end
				5'd3: begin
					mul_a = as17(cor_sin[0]);
					mul_b = bs17(cor_cos[1]);
				end
				// times y quaternion
				5'd4: begin
					mul_a = as16(tq_q[0]);
					mul_b = bs17(cor_cos[2]);
				end
				5'd5: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as16(tq_q[2]);
					mul_b   = bs17(cor_sin[2]);
				end
				5'd6: begin
					mul_a = as16(tq_q[1]);
					mul_b = bs17(cor_cos[2]);
				end
				5'd7: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as16(tq_q[3]);
					mul_b   = bs17(cor_sin[2]);
				end
				5'd8: begin
					mul_a = as16(tq_q[0]);
					mul_b = bs17(cor_sin[2]);
				end
				5'd9: begin
					mac_clr = 1'b0;
					mul_a   = as16(tq_q[2]);
					mul_b   = bs17(cor_cos[2]);
				end
				5'd10: begin
					mul_a = as16(tq_q[1]);
					mul_b = bs17(cor_sin[2]);
				end
				5'd11: begin
					mac_clr = 1'b0;
					mul_a   = as16(tq_q[3]);
					mul_b   = bs17(cor_cos[2]);
				end
				// first cross product u x v
				5'd12: begin
					mul_a = as32(v2);
					mul_b = bs16(qo_q[2]);
				end
				5'd13: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as32(v1);
					mul_b   = bs16(qo_q[3]);
				end
				5'd14: begin
					mul_a = as32(v0);
					mul_b = bs16(qo_q[3]);
				end
				5'd15: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as32(v2);
					mul_b   = bs16(qo_q[1]);
				end
				5'd16: begin
					mul_a = as32(v1);
					mul_b = bs16(qo_q[1]);
				end
				5'd17: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as32(v0);
					mul_b   = bs16(qo_q[2]);
				end
				// w t plus u x t
				5'd18: begin
					mul_a = as36(tt_q[0]);
					mul_b = bs16(qo_q[0]);
				end
				5'd19: begin
					mac_clr = 1'b0;
					mul_a   = as36(tt_q[2]);
					mul_b   = bs16(qo_q[2]);
				end
				5'd20: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as36(tt_q[1]);
					mul_b   = bs16(qo_q[3]);
				end
				5'd21: begin
					mul_a = as36(tt_q[1]);
					mul_b = bs16(qo_q[0]);
				end
				5'd22: begin
					mac_clr = 1'b0;
					mul_a   = as36(tt_q[0]);
					mul_b   = bs16(qo_q[3]);
				end
				5'd23: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as36(tt_q[2]);
					mul_b   = bs16(qo_q[1]);
				end
				5'd24: begin
					mul_a = as36(tt_q[2]);
					mul_b = bs16(qo_q[0]);
				end
				5'd25: begin
					mac_clr = 1'b0;
					mul_a   = as36(tt_q[1]);
					mul_b   = bs16(qo_q[1]);
				end
				5'd26: begin
					mac_clr = 1'b0;
					mac_sub = 1'b1;
					mul_a   = as36(tt_q[0]);
					mul_b   = bs16(qo_q[2]);
				end
				default: ;
			endcase
		end
	end

	assign prod = mul_a * mul_b;

	// camera state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fcq_pkg::ST_IDLE;
			cnt_q       <= 5'd0;
			yaw_q       <= 16'h0;
			pitch_q     <= 16'h0;
			roll_q      <= 16'h0;
			mv_q[0]     <= 32'h0;
			mv_q[1]     <= 32'h0;
			mv_q[2]     <= 32'h0;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == fcq_pkg::ST_IDLE && pop_valid && pop_item.raw.reset_angles) begin
				yaw_q   <= cfg.initial_yaw;
				pitch_q <= cfg.initial_pitch;
				roll_q  <= cfg.initial_roll;
			end
			if (state_q == fcq_pkg::ST_ANGLE) begin
				case (cnt_q)
					5'd2: yaw_q <= yaw_q + dang;
					5'd4: pitch_q <= pitch_q + (cfg.invert_look ? 16'h0 - dang : dang);
					5'd6: roll_q <= roll_q + dang;
					5'd7: mv_q[0] <= sat32(acc32(mv_q[0]) + r7);
					5'd8: mv_q[1] <= sat32(acc32(mv_q[1]) + r7);
					5'd10: begin
						mv_q[2] <= sat32(acc32(mv_q[2]) + r15);
						moved_q <= moved_q | item_q.has_move;
					end
					default: ;
				endcase
			end
			// result register, then clear the move if asked
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (item_q.raw.clear_move) begin
					mv_q[0] <= 32'h0;
					mv_q[1] <= 32'h0;
					mv_q[2] <= 32'h0;
					moved_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// accumulator and intermediate products
	always_ff @(posedge clk) begin
		acc_q <= (mac_clr ? '0 : acc_q) + (mac_sub ? -prod : prod);
		if (state_q == fcq_pkg::ST_IDLE && pop_valid)
			item_q <= pop_item;
		if (state_q == fcq_pkg::ST_QUAT) begin
			case (cnt_q)
				5'd1:  tq_q[0] <= sat16(r15);
				5'd2:  tq_q[1] <= sat16(r15);
				5'd3:  tq_q[2] <= sat16(r15);
				5'd4:  tq_q[3] <= sat16(r15);
				5'd6:  qo_q[0] <= sat16(r15);
				5'd8:  qo_q[1] <= sat16(r15);
				5'd10: qo_q[2] <= sat16(r15);
				5'd12: qo_q[3] <= sat16(r15);
				5'd14: tt_q[0] <= r14[35:0];
				5'd16: tt_q[1] <= r14[35:0];
				5'd18: tt_q[2] <= r14[35:0];
				5'd21: res_x_q <= item_q.raw.pos_x + v0 + r15[31:0];
				5'd24: res_y_q <= item_q.raw.pos_y + v1 + r15[31:0];
				5'd27: res_z_q <= item_q.raw.pos_z + v2 + r15[31:0];
				default: ;
			endcase
		end
		if (out_load) begin
			out_q.new_x  <= res_x_q;
			out_q.new_y  <= res_y_q;
			out_q.new_z  <= res_z_q;
			out_q.quat_w <= qo_q[0];
			out_q.quat_x <= qo_q[1];
			out_q.quat_y <= qo_q[2];
			out_q.quat_z <= qo_q[3];
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

endmodule

[src/free_camera_quaternion_update.sv]
`timescale 1ns / 1ps

// channel  | handshake                      | payload
// ---------+--------------------------------+----------------------------------------------
// in       | in_valid / in_ready            | amounts, pos_x..pos_z, reset_angles, clear_move
// out      | out_valid / out_ready          | new_x..new_z, quat_w..quat_z
// cfg      | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// one frame runs through eleven steps on the shared multiply-accumulate for angles and move
// vector, the three-lane rotator for the half-angle sines and cosines, then twenty-eight
// multiply-accumulate steps for quaternion products and the vector rotation. a two-entry
// queue takes frames while the back end works, and the output register lets the next frame
// start while a result waits. cfg_ready is always high. reset returns all angles, the move
// vector and the registers to their defaults.

module free_camera_quaternion_update #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] yaw_amount,
	input  logic signed [15:0] pitch_amount,
	input  logic signed [15:0] roll_amount,
	input  logic signed [15:0] forward_amount,
	input  logic signed [15:0] right_amount,
	input  logic signed [15:0] up_amount,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic               reset_angles,
	input  logic               clear_move,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_x,
	output logic signed [31:0] new_y,
	output logic signed [31:0] new_z,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	fcq_pkg::cfg_t     cfg_q;
	fcq_pkg::in_item_t in_item;
	logic              pop_valid;
	logic              pop_ready;
	fcq_pkg::item_t    pop_item;
	fcq_pkg::result_t  result;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.movement_speed <= 16'd256;
			cfg_q.rotation_speed <= 16'd256;
			cfg_q.up_multiplier  <= 16'd256;
			cfg_q.invert_look    <= 1'b0;
			cfg_q.initial_pitch  <= 16'h0;
			cfg_q.initial_yaw    <= 16'h0;
			cfg_q.initial_roll   <= 16'h0;
		end else if (cfg_valid) begin
			case (fcq_pkg::cfg_reg_t'(cfg_index))
				fcq_pkg::REG_MOVEMENT_SPEED: cfg_q.movement_speed <= cfg_data;
				fcq_pkg::REG_ROTATION_SPEED: cfg_q.rotation_speed <= cfg_data;
				fcq_pkg::REG_UP_MULTIPLIER:  cfg_q.up_multiplier  <= cfg_data;
				fcq_pkg::REG_INVERT_LOOK:    cfg_q.invert_look    <= cfg_data[0];
				fcq_pkg::REG_INITIAL_PITCH:  cfg_q.initial_pitch  <= cfg_data;
				fcq_pkg::REG_INITIAL_YAW:    cfg_q.initial_yaw    <= cfg_data;
				fcq_pkg::REG_INITIAL_ROLL:   cfg_q.initial_roll   <= cfg_data;
				default: ;
			endcase
		end
	end

	// input transaction payload
	always_comb begin
		in_item.yaw_amount     = yaw_amount;
		in_item.pitch_amount   = pitch_amount;
		in_item.roll_amount    = roll_amount;
		in_item.forward_amount = forward_amount;
		in_item.right_amount   = right_amount;
		in_item.up_amount      = up_amount;
		in_item.pos_x          = pos_x;
		in_item.pos_y          = pos_y;
		in_item.pos_z          = pos_z;
		in_item.reset_angles   = reset_angles;
		in_item.clear_move     = clear_move;
	end

	fcq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item)
	);

	fcq_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign new_x  = result.new_x;
	assign new_y  = result.new_y;
	assign new_z  = result.new_z;
	assign quat_w = result.quat_w;
	assign quat_x = result.quat_x;
	assign quat_y = result.quat_y;
	assign quat_z = result.quat_z;

endmodule

[src/fcq_checker.sv]
`timescale 1ns / 1ps

module fcq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] new_x,
	input logic signed [31:0] new_y,
	input logic signed [31:0] new_z,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// a stalled result stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(new_x) && $stable(new_y) && $stable(new_z) &&
			$stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z))
		else $error("result payload changed while stalled");

	// configuration is never back-pressured
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// out of reset the queue is empty and no result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready && !out_valid)
		else $error("block not empty after reset");

endmodule

bind free_camera_quaternion_update fcq_checker u_fcq_checker (.*);
